// ===== sv/bswr_pkg.sv =====
package bswr_pkg;

  localparam int OpW  = 3;
  localparam int ValW = 8;
  localparam int NW   = 6;
  localparam int StW  = 2;
  localparam int CapW = 6;

  localparam logic [OpW-1:0] OP_PUSH     = 3'd0;
  localparam logic [OpW-1:0] OP_POP      = 3'd1;
  localparam logic [OpW-1:0] OP_PEEK     = 3'd2;
  localparam logic [OpW-1:0] OP_DUP      = 3'd3;
  localparam logic [OpW-1:0] OP_ROT_UP   = 3'd4;
  localparam logic [OpW-1:0] OP_ROT_DOWN = 3'd5;
  localparam logic [OpW-1:0] OP_DUMP     = 3'd6;

  localparam logic [StW-1:0] ST_OK      = 2'd0;
  localparam logic [StW-1:0] ST_FULL    = 2'd1;
  localparam logic [StW-1:0] ST_EMPTY   = 2'd2;
  localparam logic [StW-1:0] ST_ROT_IGN = 2'd3;

  localparam logic [CapW-1:0] CAP_RESET = 6'd32;

  // controller -> datapath
  typedef struct packed {
    logic           push;           // store push value at count, count + 1
    logic           dup;            // store read data at count, count + 1
    logic           pop;            // count - 1
    logic           rd_top;         // read top, pointer to top
    logic           rd_next;        // read one below pointer, pointer - 1
    logic           rot_start;      // read first entry of the window
    logic           rot_down;       // direction taken at rot_start
    logic           tmp_ld;         // hold the displaced entry
    logic           rot_rd;         // read next source of the window
    logic           rot_wr;         // move read data into place, advance
    logic           rot_fin;        // drop the held entry into the last slot
    logic           emit_stat;      // result without data, last set
    logic [StW-1:0] stat;
    logic           emit_data;      // result carrying read data
    logic           last_at_bottom; // last flag follows pointer == 0
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic rot_bad;
    logic rem_zero;
    logic at_bottom;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/bswr_datapath.sv =====
module bswr_datapath #(
  parameter int DEPTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic [bswr_pkg::CapW-1:0] cfg_data_i,
  input  logic [bswr_pkg::ValW-1:0] push_value_i,
  input  logic [bswr_pkg::NW-1:0]   rotate_count_i,
  input  bswr_pkg::cmd_t         cmd_i,
  output bswr_pkg::sts_t         sts_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [bswr_pkg::StW-1:0]  status_o,
  output logic                   data_valid_o,
  output logic [bswr_pkg::ValW-1:0] data_byte_o,
  output logic                   last_o
);
  import bswr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > NW) ? CW : NW;

  logic [ValW-1:0] mem [DEPTH];

  logic [CapW-1:0] cap_q;
  logic [CW-1:0]   count_q, count_d, count_m1;
  logic [AW-1:0]   ptr_q, dst_q, rem_q, dst_next;
  logic            dir_q;
  logic [ValW-1:0] tmp_q, rd_data_q;

  logic [XW-1:0]   cap_x, cap_used, count_x, n_x, base_x, rem_x;
  logic [AW-1:0]   top_addr, base_addr;

  logic            wr_en, rd_en;
  logic [AW-1:0]   wr_addr, rd_addr;
  logic [ValW-1:0] wr_data;

  logic            out_valid_q, out_free;
  logic [StW-1:0]  status_q;
  logic            dv_q, last_q;
  logic [ValW-1:0] byte_q;

  always_comb begin
    cap_x   = XW'(cap_q);
    count_x = XW'(count_q);
    n_x     = XW'(rotate_count_i);
    if (cap_x == '0) begin
      cap_used = XW'(1);
    end else if (cap_x > XW'(DEPTH)) begin
      cap_used = XW'(DEPTH);
    end else begin
      cap_used = cap_x;
    end
    count_m1  = count_q - CW'(1);
    top_addr  = count_m1[AW-1:0];
    base_x    = count_x - n_x;
    base_addr = base_x[AW-1:0];
    rem_x     = n_x - XW'(1);
    dst_next  = dir_q ? (dst_q + AW'(1)) : (dst_q - AW'(1));
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_x >= cap_used);
  assign sts_o.rot_bad   = (n_x < XW'(2)) || (n_x > cap_used) || (n_x > count_x);
  assign sts_o.rem_zero  = (rem_q == '0);
  assign sts_o.at_bottom = (ptr_q == '0);
  assign sts_o.out_free  = out_free;

  // single write port, single registered read port
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = count_q[AW-1:0];
    wr_data = push_value_i;
    if (cmd_i.push) begin
      wr_data = push_value_i;
    end else if (cmd_i.dup) begin
      wr_data = rd_data_q;
    end else if (cmd_i.rot_wr) begin
      wr_addr = dst_q;
      wr_data = rd_data_q;
    end else if (cmd_i.rot_fin) begin
      wr_addr = dst_q;
      wr_data = tmp_q;
    end else begin
      wr_en = 1'b0;
    end

    rd_en   = 1'b1;
    rd_addr = top_addr;
    if (cmd_i.rd_top) begin
      rd_addr = top_addr;
    end else if (cmd_i.rd_next) begin
      rd_addr = ptr_q - AW'(1);
    end else if (cmd_i.rot_start) begin
      rd_addr = cmd_i.rot_down ? base_addr : top_addr;
    end else if (cmd_i.rot_rd) begin
      rd_addr = dst_next;
    end else begin
      rd_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push || cmd_i.dup) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q   <= CAP_RESET;
      count_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      count_q <= count_d;
    end
  end

  // walk pointers and held entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_top) begin
      ptr_q <= top_addr;
    end else if (cmd_i.rd_next) begin
      ptr_q <= ptr_q - AW'(1);
    end
    if (cmd_i.rot_start) begin
      dst_q <= cmd_i.rot_down ? base_addr : top_addr;
      rem_q <= rem_x[AW-1:0];
      dir_q <= cmd_i.rot_down;
    end else if (cmd_i.rot_wr) begin
      dst_q <= dst_next;
      rem_q <= rem_q - AW'(1);
    end
    if (cmd_i.tmp_ld) begin
      tmp_q <= rd_data_q;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_stat || cmd_i.emit_data) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_stat) begin
      status_q <= cmd_i.stat;
      dv_q     <= 1'b0;
      byte_q   <= '0;
      last_q   <= 1'b1;
    end else if (cmd_i.emit_data) begin
      status_q <= ST_OK;
      dv_q     <= 1'b1;
      byte_q   <= rd_data_q;
      last_q   <= cmd_i.last_at_bottom ? (ptr_q == '0) : 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_valid_o = dv_q;
  assign data_byte_o  = byte_q;
  assign last_o       = last_q;

endmodule

// ===== sv/bswr_ctrl.sv =====
module bswr_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [bswr_pkg::OpW-1:0] op_i,
  input  bswr_pkg::sts_t           sts_i,
  output bswr_pkg::cmd_t           cmd_o
);
  import bswr_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TOP     = 3'd1;
  localparam logic [2:0] S_ROT_TMP = 3'd2;
  localparam logic [2:0] S_ROT_RD  = 3'd3;
  localparam logic [2:0] S_ROT_WR  = 3'd4;
  localparam logic [2:0] S_DUMP    = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [OpW-1:0] op_q, op_d;
  logic           accept;

  assign in_ready_o = (state_q == S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d = op_i;
          unique case (op_i) inside
            OP_PUSH: begin
              cmd_o.emit_stat = 1'b1;
              if (sts_i.full) begin
                cmd_o.stat = ST_FULL;
              end else begin
                cmd_o.stat = ST_OK;
                cmd_o.push = 1'b1;
              end
            end
            OP_POP, OP_PEEK: begin
              if (sts_i.empty) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat      = ST_EMPTY;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_TOP;
              end
            end
            OP_DUP: begin
              if (sts_i.empty) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat      = ST_EMPTY;
              end else if (sts_i.full) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat      = ST_FULL;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_TOP;
              end
            end
            OP_ROT_UP, OP_ROT_DOWN: begin
              if (sts_i.rot_bad) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat      = ST_ROT_IGN;
              end else begin
                cmd_o.rot_start = 1'b1;
                cmd_o.rot_down  = (op_i == OP_ROT_DOWN);
                state_d         = S_ROT_TMP;
              end
            end
            OP_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.emit_stat = 1'b1;
                cmd_o.stat      = ST_EMPTY;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = S_DUMP;
              end
            end
            default: begin
              cmd_o.emit_stat = 1'b1;
              cmd_o.stat      = ST_OK;
            end
          endcase
        end
      end
      // top entry sits in the read register; output slot is still free
      S_TOP: begin
        if (op_q == OP_DUP) begin
          cmd_o.dup       = 1'b1;
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat      = ST_OK;
        end else begin
          cmd_o.emit_data = 1'b1;
          cmd_o.pop       = (op_q == OP_POP);
        end
        state_d = S_IDLE;
      end
      S_ROT_TMP: begin
        cmd_o.tmp_ld = 1'b1;
        state_d      = S_ROT_RD;
      end
      S_ROT_RD: begin
        if (sts_i.rem_zero) begin
          cmd_o.rot_fin   = 1'b1;
          cmd_o.emit_stat = 1'b1;
          cmd_o.stat      = ST_OK;
          state_d         = S_IDLE;
        end else begin
          cmd_o.rot_rd = 1'b1;
          state_d      = S_ROT_WR;
        end
      end
      S_ROT_WR: begin
        cmd_o.rot_wr = 1'b1;
        state_d      = S_ROT_RD;
      end
      // one entry per transfer, next read issued alongside
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.emit_data      = 1'b1;
          cmd_o.last_at_bottom = 1'b1;
          if (sts_i.at_bottom) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_PUSH;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

endmodule

// ===== sv/byte_stack_with_rotate_top.sv =====
// Bounded byte stack with duplicate and rotate.
// Commands come in on the s_axis channel (operation in tuser, push value and
// rotate count in tdata); each produces results on the m_axis channel
// (status and data-valid flag in tuser, entry byte in tdata, tlast on the
// final result of a command). cfg_valid_i/cfg_data_i writes the capacity
// limit (clamped to 1..DEPTH); write it only while the stack is idle.
// One command is in flight at a time; s_axis_tready is high when the
// controller is idle and the output register is empty or being drained.
// Steps per command, from accept to result loaded in the output register:
//   push, rejects, ignored rotates, unknown codes: loaded at accept
//   pop, peek, duplicate: registered read of the top entry, then the result
//   rotate of n entries: hold the displaced entry, one read and one write
//     per moved entry on the single-port stack memory, drop the held entry
//   dump of c entries: one result per cycle while the receiver takes it
// A stalled receiver holds the output register and stops the dump walk.
// Reset empties the stack and sets the capacity limit to 32; no clearing
// pass is needed, entries above the count are never read.
module byte_stack_with_rotate_top #(
  parameter int DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,     // capacity_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] push_value, [13:8] rotate_count
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] data_valid
  output logic        m_axis_tlast
);
  import bswr_pkg::*;

  cmd_t           cmd;
  sts_t           sts;
  logic [StW-1:0] status;
  logic           data_valid;

  assign cfg_ready_o = 1'b1;

  bswr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bswr_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .push_value_i   (s_axis_tdata[7:0]),
    .rotate_count_i (s_axis_tdata[13:8]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .status_o       (status),
    .data_valid_o   (data_valid),
    .data_byte_o    (m_axis_tdata),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tuser = {data_valid, status};

endmodule

// ===== sv/bswr_checker.sv =====
module bswr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);
  import bswr_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // a new command is only taken when the output slot drains
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && m_axis_tvalid |-> m_axis_tready)
    else $error("input taken while output stalled");

  a_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == ST_OK)
    else $error("data result with non-ok status");

  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[2] |-> m_axis_tdata == '0 && m_axis_tlast)
    else $error("status-only result malformed");

  // only a dump spans several results, and it never ends in a status-only one
  a_multi_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      !(m_axis_tvalid && !m_axis_tuser[2]))
    else $error("dump interrupted by a status result");

endmodule

bind byte_stack_with_rotate_top bswr_checker u_bswr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
